/* design/particle_integrate_wrap_top_assert.svh */
// ---------------------------------------------------------------------------
// particle_integrate_wrap_top_assert.svh
// Assertion macros used by the particle integrator top.
// ---------------------------------------------------------------------------
`ifndef PARTICLE_INTEGRATE_WRAP_TOP_ASSERT_SVH
`define PARTICLE_INTEGRATE_WRAP_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PIW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define PIW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/piw_pkg.sv */
// ---------------------------------------------------------------------------
// piw_pkg
// Types, codes and helper functions of the particle integrator.
// ---------------------------------------------------------------------------
`default_nettype none

package piw_pkg;

	localparam int AXES      = 3;
	localparam int AXIS_W    = $clog2(AXES + 1);
	localparam int SD_STEPS  = 32;
	localparam int SD_CNT_W  = $clog2(SD_STEPS);
	localparam int SD_REM_W  = 35;

	// register indexes on the config port
	localparam logic [2:0] REG_MIN_X       = 3'd0;
	localparam logic [2:0] REG_MAX_X       = 3'd1;
	localparam logic [2:0] REG_MIN_Y       = 3'd2;
	localparam logic [2:0] REG_MAX_Y       = 3'd3;
	localparam logic [2:0] REG_MIN_Z       = 3'd4;
	localparam logic [2:0] REG_MAX_Z       = 3'd5;
	localparam logic [2:0] REG_SPEED_LIMIT = 3'd6;

	localparam logic signed [31:0] MIN_RESET = 32'sd0;
	localparam logic signed [31:0] MAX_RESET = 32'sd65536;
	localparam logic [30:0]        LIM_RESET = 31'd655;

	typedef enum logic [2:0] {
		OP_FORCE  = 3'd0,
		OP_STEP   = 3'd1,
		OP_OFFSET = 3'd2,
		OP_SETPOS = 3'd3,
		OP_WRAP   = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACCEL,
		ST_SQ,
		ST_CMP,
		ST_SQRT,
		ST_MUL,
		ST_DIV_LD,
		ST_DIV,
		ST_POS1,
		ST_POS2,
		ST_OUT
	} state_t;

	typedef enum logic {
		SD_SQRT,
		SD_DIV
	} sd_mode_t;

	typedef struct packed {
		logic     start;
		sd_mode_t mode;
	} sd_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sd_stat_t;

	// saturating signed 32-bit add
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			sat_add = s[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
		end else begin
			sat_add = s[31:0];
		end
	endfunction

	// magnitude; the most negative value maps to 2^31
	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		mag32 = v[31] ? (32'd0 - v) : v;
	endfunction

	// move to the opposite bound: high test first, then low test
	function automatic logic signed [31:0] wrap_axis(input logic signed [31:0] p,
		input logic signed [31:0] mn, input logic signed [31:0] mx);
		logic signed [31:0] p1;
		p1 = (p >= mx) ? mn : p;
		wrap_axis = (p1 < mn) ? mx : p1;
	endfunction

endpackage

`default_nettype wire

/* design/piw_sqdiv.sv */
// ---------------------------------------------------------------------------
// piw_sqdiv
// Shared shift-subtract unit: 64-bit integer square root or 64/32 divide.
// ---------------------------------------------------------------------------
`default_nettype none

module piw_sqdiv
	import piw_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sd_ctrl_t            ctrl,
	input  wire logic [63:0]         src,
	input  wire logic [SD_REM_W-1:0] rem_init,
	input  wire logic [31:0]         divisor,
	output sd_stat_t                 stat,
	output logic [31:0]              res
);

	sd_mode_t              mode_q;
	logic [SD_REM_W-1:0]   rem_q;
	logic [63:0]           src_q;
	logic [31:0]           res_q;
	logic [31:0]           div_q;
	logic [SD_CNT_W-1:0]   cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [SD_REM_W-1:0]   rem_t;
	logic [SD_REM_W-1:0]   trial;
	logic                  ge;

	// one digit: root takes two source bits, quotient takes one
	always_comb begin
		if (mode_q == SD_SQRT) begin
			rem_t = {rem_q[SD_REM_W-3:0], src_q[63:62]};
			trial = {1'b0, res_q, 2'b01};
		end else begin
			rem_t = {rem_q[SD_REM_W-2:0], src_q[63]};
			trial = {3'b000, div_q};
		end
		ge = (rem_t >= trial);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SD_CNT_W'(SD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			mode_q <= ctrl.mode;
			rem_q  <= rem_init;
			src_q  <= src;
			div_q  <= divisor;
			res_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_t - trial) : rem_t;
			res_q <= {res_q[30:0], ge};
			src_q <= (mode_q == SD_SQRT) ? {src_q[61:0], 2'b00} : {src_q[62:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign res       = res_q;

endmodule

`default_nettype wire

/* design/particle_integrate_wrap_top.sv */
// ---------------------------------------------------------------------------
// particle_integrate_wrap_top
// One 3D Q16.16 particle: force, Euler step with speed limit, offset,
// set position and wrap; every request returns the position.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  in        in         in_valid/in_stall   operation, vec_*, jitter_*
//  out       out        out_valid/out_stall pos_x, pos_y, pos_z
//  cfg       in         cfg_wen             cfg_idx, cfg_wdata
//
//  Force, offset, set position, wrap: IDLE, then OUT, where the result is registered.
//  Step: ACCEL, SQ, CMP, POS1, POS2, OUT; over the limit, SQRT after CMP, then MUL,
//  DIV_LD, DIV per axis, on the shared shift-subtract unit (32 root digits, then 32
//  quotient digits per axis) and the one shared 32x32 multiplier.
//  One request at a time; in_stall is high until the result is registered.
//  A waiting result does not block the next request. Reset clears state.
// ---------------------------------------------------------------------------
`default_nettype none

module particle_integrate_wrap_top
	import piw_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         operation,
	input  wire logic signed [31:0] vec_x,
	input  wire logic signed [31:0] vec_y,
	input  wire logic signed [31:0] vec_z,
	input  wire logic signed [31:0] jitter_x,
	input  wire logic signed [31:0] jitter_y,
	input  wire logic signed [31:0] jitter_z,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z,
	// config port
	input  wire logic               cfg_wen,
	input  wire logic [2:0]         cfg_idx,
	input  wire logic [31:0]        cfg_wdata
);

	`include "particle_integrate_wrap_top_assert.svh"

	state_t               state_q, state_d;

	logic signed [31:0]   pos_q [AXES];
	logic signed [31:0]   vel_q [AXES];
	logic signed [31:0]   acc_q [AXES];
	logic signed [31:0]   jit_q [AXES];
	logic signed [31:0]   cmin_q [AXES];
	logic signed [31:0]   cmax_q [AXES];
	logic [30:0]          lim_q;

	logic [AXIS_W-1:0]    cnt_q;
	logic [63:0]          prod_q;
	logic [63:0]          sum_q;
	logic [31:0]          len_q;

	logic                 out_valid_q;
	logic signed [31:0]   out_q [AXES];

	logic signed [31:0]   vec [AXES];
	logic signed [31:0]   vel_cur;
	logic [31:0]          mag_cur;
	logic [31:0]          mul_a;
	logic [31:0]          mul_b;
	logic [31:0]          lim_ext;
	logic signed [31:0]   quot;
	logic                 in_acc;
	logic                 out_free;
	logic                 need_limit;

	sd_ctrl_t             sd_ctrl;
	sd_stat_t             sd_stat;
	logic [63:0]          sd_src;
	logic [SD_REM_W-1:0]  sd_rem;
	logic [31:0]          sd_res;

	assign vec[0]     = vec_x;
	assign vec[1]     = vec_y;
	assign vec[2]     = vec_z;
	assign lim_ext    = {1'b0, lim_q};
	assign in_acc     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign need_limit = (sum_q > prod_q);
	assign quot       = {1'b0, sd_res[30:0]};

	// velocity of the axis under work
	always_comb begin
		unique case (cnt_q)
			2'd0:    vel_cur = vel_q[0];
			2'd1:    vel_cur = vel_q[1];
			default: vel_cur = vel_q[2];
		endcase
		mag_cur = mag32(vel_cur);
	end

	// shared multiplier operands: squares, limit squared, then |v| * limit
	always_comb begin
		if (state_q == ST_SQ && cnt_q == 2'd3) begin
			mul_a = lim_ext;
			mul_b = lim_ext;
		end else if (state_q == ST_SQ) begin
			mul_a = mag_cur;
			mul_b = mag_cur;
		end else begin
			mul_a = mag_cur;
			mul_b = lim_ext;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer
	always_comb begin
		state_d      = state_q;
		in_stall     = 1'b1;
		sd_ctrl.start = 1'b0;
		sd_ctrl.mode  = SD_DIV;
		sd_src       = {prod_q[31:0], 32'b0};
		sd_rem       = {4'b0000, prod_q[62:32]};
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = (op_t'(operation) == OP_STEP) ? ST_ACCEL : ST_OUT;
				end
			end
			ST_ACCEL: state_d = ST_SQ;
			ST_SQ: begin
				if (cnt_q == 2'd3) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				sd_src       = sum_q;
				sd_rem       = '0;
				sd_ctrl.mode = SD_SQRT;
				if (need_limit) begin
					sd_ctrl.start = 1'b1;
					state_d       = ST_SQRT;
				end else begin
					state_d = ST_POS1;
				end
			end
			ST_SQRT: begin
				if (sd_stat.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:   state_d = ST_DIV_LD;
			ST_DIV_LD: begin
				sd_ctrl.start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (sd_stat.done) begin
					state_d = (cnt_q == 2'd2) ? ST_POS1 : ST_MUL;
				end
			end
			ST_POS1:  state_d = ST_POS2;
			ST_POS2:  state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				cmin_q[i] <= MIN_RESET;
				cmax_q[i] <= MAX_RESET;
			end
			lim_q <= LIM_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_MIN_X:       cmin_q[0] <= cfg_wdata;
				REG_MAX_X:       cmax_q[0] <= cfg_wdata;
				REG_MIN_Y:       cmin_q[1] <= cfg_wdata;
				REG_MAX_Y:       cmax_q[1] <= cfg_wdata;
				REG_MIN_Z:       cmin_q[2] <= cfg_wdata;
				REG_MAX_Z:       cmax_q[2] <= cfg_wdata;
				REG_SPEED_LIMIT: lim_q     <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	// particle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (op_t'(operation))
							OP_FORCE: begin
								for (int i = 0; i < AXES; i++) begin
									acc_q[i] <= sat_add(acc_q[i], vec[i]);
								end
							end
							OP_OFFSET: begin
								for (int i = 0; i < AXES; i++) begin
									pos_q[i] <= sat_add(pos_q[i], vec[i]);
								end
							end
							OP_SETPOS: begin
								for (int i = 0; i < AXES; i++) begin
									pos_q[i] <= vec[i];
									vel_q[i] <= '0;
									acc_q[i] <= '0;
								end
							end
							OP_WRAP: begin
								for (int i = 0; i < AXES; i++) begin
									pos_q[i] <= wrap_axis(pos_q[i], cmin_q[i], cmax_q[i]);
								end
							end
							default: ;
						endcase
					end
				end
				ST_ACCEL: begin
					for (int i = 0; i < AXES; i++) begin
						vel_q[i] <= sat_add(vel_q[i], acc_q[i]);
					end
				end
				ST_DIV: begin
					// scaled component keeps the sign of the old one
					if (sd_stat.done) begin
						vel_q[cnt_q[1:0]] <= vel_cur[31] ? (32'sd0 - quot) : quot;
					end
				end
				ST_POS1: begin
					for (int i = 0; i < AXES; i++) begin
						pos_q[i] <= sat_add(pos_q[i], vel_q[i]);
					end
				end
				ST_POS2: begin
					for (int i = 0; i < AXES; i++) begin
						pos_q[i] <= sat_add(pos_q[i], jit_q[i]);
						acc_q[i] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// axis counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			priority if (state_q == ST_ACCEL || state_q == ST_SQRT) begin
				cnt_q <= '0;
			end else if (state_q == ST_SQ) begin
				cnt_q <= (cnt_q == 2'd3) ? 2'd0 : cnt_q + 1'b1;
			end else if (state_q == ST_DIV && sd_stat.done) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// limiter datapath: jitter capture, multiplier, sum of squares, length
	always_ff @(posedge clk) begin
		if (in_acc) begin
			jit_q[0] <= jitter_x;
			jit_q[1] <= jitter_y;
			jit_q[2] <= jitter_z;
		end
		if (state_q == ST_SQ || state_q == ST_MUL) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_ACCEL) begin
			sum_q <= '0;
		end else if (state_q == ST_SQ && cnt_q != 2'd0) begin
			sum_q <= sum_q + prod_q;
		end
		if (state_q == ST_SQRT && sd_stat.done) begin
			len_q <= sd_res;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			for (int i = 0; i < AXES; i++) begin
				out_q[i] <= pos_q[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = out_q[0];
	assign pos_y     = out_q[1];
	assign pos_z     = out_q[2];

	piw_sqdiv u_sqdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (sd_ctrl),
		.src      (sd_src),
		.rem_init (sd_rem),
		.divisor  (len_q),
		.stat     (sd_stat),
		.res      (sd_res)
	);

	// checks
	`PIW_ASSERT_NXT(a_accept_leaves_idle, in_acc, state_q != ST_IDLE,
		"accepted request did not start work")
	`PIW_ASSERT_IMP(a_start_when_free, sd_ctrl.start, !sd_stat.busy,
		"shared unit started while busy")
	`PIW_ASSERT_IMP(a_wait_on_unit, (state_q == ST_SQRT) || (state_q == ST_DIV),
		sd_stat.busy || sd_stat.done, "sequencer waits on an idle unit")
	`PIW_ASSERT_IMP(a_quot_le_limit, (state_q == ST_DIV) && sd_stat.done,
		sd_res <= lim_ext, "scaled component above speed limit")

endmodule

`default_nettype wire
